@@ design/dfrm_pkg.sv @@
// shared widths, register codes and reset values of the distance field ray march
`timescale 1ns / 1ps
`default_nettype none

package dfrm_pkg;

    // field widths
    localparam int OP_W       = 1;
    localparam int IDX_W      = 8;
    localparam int CELL_W     = 16;
    localparam int COORD_W    = 24;
    localparam int HEAD_W     = 16;
    localparam int DIST_W     = 23;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DIM_W      = 9;
    localparam int PSIZE_W    = 16;
    localparam int PSCALE_W   = 24;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SIZE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SCALE = 2'd3;

    localparam logic [DIM_W-1:0]    MAP_COLUMNS_RST = 9'd256;
    localparam logic [DIM_W-1:0]    MAP_ROWS_RST    = 9'd256;
    localparam logic [PSIZE_W-1:0]  PIXEL_SIZE_RST  = 16'd26;
    localparam logic [PSCALE_W-1:0] PIXEL_SCALE_RST = 24'd645278;

    // op codes
    localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

    // shared multiplier: position (26 bit signed) by distance or scale (25 bit signed)
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // rounding shifts of the heading offset and of the pixel index
    localparam int OFS_SHIFT = 14;
    localparam int PIX_SHIFT = 24;
    localparam int PIX_W     = PROD_W - PIX_SHIFT;

    // step margin of 1.5 pixel sizes
    localparam int EPS_W = PSIZE_W + 1;

    // default sizes
    localparam int MAX_COLUMNS_DEF = 256;
    localparam int MAX_ROWS_DEF    = 256;
    localparam int MAX_STEPS_DEF   = 1024;

endpackage

`default_nettype wire

@@ design/dfrm_mul.sv @@
// shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none

module dfrm_mul
(
    input  wire                                 clk,
    input  wire signed [dfrm_pkg::MUL_A_W-1:0]  mul_a,
    input  wire signed [dfrm_pkg::MUL_B_W-1:0]  mul_b,
    output logic signed [dfrm_pkg::PROD_W-1:0]  prod_reg
);
    import dfrm_pkg::*;

    logic signed [PROD_W-1:0] prod_next;

    // full precision product
    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

@@ design/dfrm_map.sv @@
// distance map storage, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module dfrm_map #(
    parameter int DEPTH = dfrm_pkg::MAX_COLUMNS_DEF * dfrm_pkg::MAX_ROWS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  wire                          clk,
    input  wire                          wr_en,
    input  wire  [ADDR_W-1:0]            wr_addr,
    input  wire  [dfrm_pkg::CELL_W-1:0]  wr_data,
    input  wire                          rd_en,
    input  wire  [ADDR_W-1:0]            rd_addr,
    output logic [dfrm_pkg::CELL_W-1:0]  rd_data_reg
);
    import dfrm_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];

    // cell writes and sample reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/distance_field_ray_march.sv @@
// sphere tracing ray march over a 2-d signed distance map
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | op, cell_column, cell_row, cell_distance,
//           |                      | start_x, start_y, heading_x, heading_y,
//           |                      | range_limit
//  output   | out_valid/out_stall  | travelled, wall_found, step_bound_hit
//  config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  a write item leaves the input free for the next item; a query runs the states MX, MY,
//  SX, SY, CY, RQ and EV once per march step (at most MAX_STEPS steps), in sequence through
//  the one shared multiplier (two offset and two pixel products per step) and the registered map read
//  reset restores the configuration defaults; map contents are undefined until written
//  a finished result waits in the output register while the next item is taken;
//  a query that ends while that register is still held waits in its last step
`timescale 1ns / 1ps
`default_nettype none

module distance_field_ray_march #(
    parameter int MAX_COLUMNS = dfrm_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = dfrm_pkg::MAX_ROWS_DEF,
    parameter int MAX_STEPS   = dfrm_pkg::MAX_STEPS_DEF
)
(
    input  wire                                  clk,
    input  wire                                  rst_n,
    // item input
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire  [dfrm_pkg::OP_W-1:0]            op,
    input  wire  [dfrm_pkg::IDX_W-1:0]           cell_column,
    input  wire  [dfrm_pkg::IDX_W-1:0]           cell_row,
    input  wire signed [dfrm_pkg::CELL_W-1:0]    cell_distance,
    input  wire signed [dfrm_pkg::COORD_W-1:0]   start_x,
    input  wire signed [dfrm_pkg::COORD_W-1:0]   start_y,
    input  wire signed [dfrm_pkg::HEAD_W-1:0]    heading_x,
    input  wire signed [dfrm_pkg::HEAD_W-1:0]    heading_y,
    input  wire  [dfrm_pkg::DIST_W-1:0]          range_limit,
    // result output
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic [dfrm_pkg::DIST_W-1:0]          travelled,
    output logic                                 wall_found,
    output logic                                 step_bound_hit,
    // configuration writes
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [dfrm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [dfrm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import dfrm_pkg::*;

    localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int STEP_W = $clog2(MAX_STEPS);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MX   = 3'd1;
    localparam logic [2:0] S_MY   = 3'd2;
    localparam logic [2:0] S_SX   = 3'd3;
    localparam logic [2:0] S_SY   = 3'd4;
    localparam logic [2:0] S_CY   = 3'd5;
    localparam logic [2:0] S_RQ   = 3'd6;
    localparam logic [2:0] S_EV   = 3'd7;

    localparam logic signed [PROD_W-1:0] OFS_HALF = PROD_W'(1) << (OFS_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] PIX_HALF = PROD_W'(1) << (PIX_SHIFT - 1);

    logic [2:0]              state_reg;
    logic [2:0]              state_next;

    logic [DIM_W-1:0]        map_columns_reg;
    logic [DIM_W-1:0]        map_rows_reg;
    logic [PSIZE_W-1:0]      pixel_size_reg;
    logic [PSCALE_W-1:0]     pixel_scale_reg;

    logic signed [COORD_W-1:0] sx_reg;
    logic signed [COORD_W-1:0] sy_reg;
    logic signed [HEAD_W-1:0]  hx_reg;
    logic signed [HEAD_W-1:0]  hy_reg;
    logic [DIST_W-1:0]         limit_reg;
    logic [DIST_W-1:0]         t_reg;
    logic [STEP_W-1:0]         step_cnt_reg;
    logic signed [MUL_A_W-1:0] px_reg;
    logic signed [MUL_A_W-1:0] py_reg;
    logic [COL_W-1:0]          cx_reg;
    logic [ROW_W-1:0]          cy_reg;

    logic                    out_valid_reg;
    logic [DIST_W-1:0]       travelled_reg;
    logic                    wall_found_reg;
    logic                    step_bound_hit_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;

    logic signed [PROD_W-1:0]  ofs_sum;
    logic signed [PROD_W-1:0]  pix_sum;
    logic signed [MUL_A_W-1:0] ofs;
    logic signed [MUL_A_W-1:0] pos_next;
    logic signed [PIX_W-1:0]   pix;
    logic [COL_W-1:0]          cx_next;
    logic [ROW_W-1:0]          cy_next;
    logic [COL_W-1:0]          col_last;
    logic [ROW_W-1:0]          row_last;

    logic [EPS_W:0]          eps_sum;
    logic [EPS_W-1:0]        eps;
    logic [DIST_W:0]         t_sum;

    logic                    in_accept;
    logic                    query_start;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic [CELL_W-1:0]       rd_data_reg;

    logic                    wall_hit;
    logic                    limit_hit;
    logic                    last_step;
    logic                    march_done;
    logic                    out_free;
    logic                    res_load;

    // handshake
    assign in_stall    = (state_reg != S_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign query_start = in_accept && (op == OP_QUERY);
    assign cfg_ready   = 1'b1;

    assign out_valid      = out_valid_reg;
    assign travelled      = travelled_reg;
    assign wall_found     = wall_found_reg;
    assign step_bound_hit = step_bound_hit_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_columns_reg <= MAP_COLUMNS_RST;
            map_rows_reg    <= MAP_ROWS_RST;
            pixel_size_reg  <= PIXEL_SIZE_RST;
            pixel_scale_reg <= PIXEL_SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAP_COLUMNS: map_columns_reg <= cfg_data[DIM_W-1:0];
                REG_MAP_ROWS:    map_rows_reg    <= cfg_data[DIM_W-1:0];
                REG_PIXEL_SIZE:  pixel_size_reg  <= cfg_data[PSIZE_W-1:0];
                REG_PIXEL_SCALE: pixel_scale_reg <= cfg_data[PSCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // last usable column and row of the map in use
    always_comb
    begin
        if (map_columns_reg == '0)
            col_last = '0;
        else if (32'(map_columns_reg) > MAX_COLUMNS)
            col_last = COL_W'(MAX_COLUMNS - 1);
        else
            col_last = COL_W'(map_columns_reg - 1'b1);

        if (map_rows_reg == '0)
            row_last = '0;
        else if (32'(map_rows_reg) > MAX_ROWS)
            row_last = ROW_W'(MAX_ROWS - 1);
        else
            row_last = ROW_W'(map_rows_reg - 1'b1);
    end

    // step margin: 1.5 pixel sizes, halves rounded up
    assign eps_sum = (EPS_W + 1)'(pixel_size_reg) * (EPS_W + 1)'(3) + (EPS_W + 1)'(1);
    assign eps     = eps_sum[EPS_W:1];

    // map write for a cell item inside storage
    assign wr_en   = in_accept && (op == OP_WRITE)
                     && (32'(cell_column) < MAX_COLUMNS) && (32'(cell_row) < MAX_ROWS);
    assign wr_addr = ADDR_W'(ADDR_W'(cell_row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(cell_column));

    // sample read at the clamped pixel
    assign rd_en   = (state_reg == S_RQ);
    assign rd_addr = ADDR_W'(ADDR_W'(cy_reg) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(cx_reg));

    // operand selection for the shared multiplier
    always_comb
    begin
        case (state_reg)
            S_MX:
            begin
                mul_a = MUL_A_W'(hx_reg);
                mul_b = $signed(MUL_B_W'(t_reg));
            end
            S_MY:
            begin
                mul_a = MUL_A_W'(hy_reg);
                mul_b = $signed(MUL_B_W'(t_reg));
            end
            S_SX:
            begin
                mul_a = px_reg;
                mul_b = $signed(MUL_B_W'(pixel_scale_reg));
            end
            S_SY:
            begin
                mul_a = py_reg;
                mul_b = $signed(MUL_B_W'(pixel_scale_reg));
            end
            default:
            begin
                mul_a = px_reg;
                mul_b = $signed(MUL_B_W'(pixel_scale_reg));
            end
        endcase
    end

    dfrm_mul u_mul (
        .clk      (clk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    // offset rounding, ties away from zero, and position
    assign ofs_sum  = prod_reg + OFS_HALF - $signed(PROD_W'(prod_reg[PROD_W-1]));
    assign ofs      = $signed(ofs_sum[OFS_SHIFT + MUL_A_W - 1:OFS_SHIFT]);
    assign pos_next = ((state_reg == S_MY) ? MUL_A_W'(sx_reg) : MUL_A_W'(sy_reg)) + ofs;

    // pixel rounding, ties away from zero, then clamp to the map in use
    assign pix_sum = prod_reg + PIX_HALF - $signed(PROD_W'(prod_reg[PROD_W-1]));
    assign pix     = $signed(pix_sum[PROD_W-1:PIX_SHIFT]);

    always_comb
    begin
        if (pix < 0)
            cx_next = '0;
        else if (pix > $signed({1'b0, col_last}))
            cx_next = col_last;
        else
            cx_next = pix[COL_W-1:0];

        if (pix < 0)
            cy_next = '0;
        else if (pix > $signed({1'b0, row_last}))
            cy_next = row_last;
        else
            cy_next = pix[ROW_W-1:0];
    end

    dfrm_map #(
        .DEPTH (DEPTH)
    ) u_map (
        .clk         (clk),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (cell_distance),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data_reg (rd_data_reg)
    );

    // end of step decision
    assign t_sum      = (DIST_W + 1)'(t_reg) + (DIST_W + 1)'(rd_data_reg) + (DIST_W + 1)'(eps);
    assign wall_hit   = rd_data_reg[CELL_W-1];
    assign limit_hit  = (t_sum >= (DIST_W + 1)'(limit_reg));
    assign last_step  = (step_cnt_reg == STEP_W'(MAX_STEPS - 1));
    assign march_done = wall_hit || limit_hit || last_step;
    assign out_free   = !out_valid_reg || !out_stall;
    assign res_load   = (state_reg == S_EV) && march_done && out_free;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (query_start)
                    state_next = S_MX;
            end
            S_MX: state_next = S_MY;
            S_MY: state_next = S_SX;
            S_SX: state_next = S_SY;
            S_SY: state_next = S_CY;
            S_CY: state_next = S_RQ;
            S_RQ: state_next = S_EV;
            S_EV:
            begin
                if (!march_done)
                    state_next = S_MX;
                else if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // march datapath
    always_ff @(posedge clk)
    begin
        if (query_start)
        begin
            sx_reg       <= start_x;
            sy_reg       <= start_y;
            hx_reg       <= heading_x;
            hy_reg       <= heading_y;
            limit_reg    <= range_limit;
            t_reg        <= '0;
            step_cnt_reg <= '0;
        end
        if (state_reg == S_MY)
            px_reg <= pos_next;
        if (state_reg == S_SX)
            py_reg <= pos_next;
        if (state_reg == S_SY)
            cx_reg <= cx_next;
        if (state_reg == S_CY)
            cy_reg <= cy_next;
        if ((state_reg == S_EV) && !march_done)
        begin
            t_reg        <= t_sum[DIST_W-1:0];
            step_cnt_reg <= step_cnt_reg + 1'b1;
        end
        // result register
        if (res_load)
        begin
            wall_found_reg     <= wall_hit;
            step_bound_hit_reg <= !wall_hit && !limit_hit;
            travelled_reg      <= wall_hit ? t_reg : limit_reg;
        end
    end

    // a result carries at most one end flag
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(wall_found_reg && step_bound_hit_reg))
        else $error("wall and step bound flagged together");

    // a result appears only out of the decision state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_EV))
        else $error("result loaded outside the decision state");

    // the march continues only below the range limit
    a_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MX) && (step_cnt_reg != '0)) |-> (t_reg < limit_reg))
        else $error("march continued at or past the range limit");

    // the read address stays inside the map in use
    a_read_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RQ) |-> ((cx_reg <= col_last) && (cy_reg <= row_last)))
        else $error("sample read outside the map in use");

endmodule

`default_nettype wire

@@ dv/distance_field_ray_march_tb.sv @@
// self-checking testbench of the distance field ray march: directed rows, then random phases
`timescale 1ns / 1ps

module distance_field_ray_march_tb;

    import dfrm_pkg::*;

    localparam int COLS_MAX        = MAX_COLUMNS_DEF;
    localparam int ROWS_MAX        = MAX_ROWS_DEF;
    localparam int STEP_BOUND      = MAX_STEPS_DEF;
    localparam int QUIET_LIMIT     = 40000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int ITEMS_PER_PHASE = 56;
    localparam int PHASES          = 6;
    // side of the filled corner block; column 0 is filled down to the last row
    localparam int FILL_DIM        = 10;

    typedef struct packed {
        logic [DIST_W-1:0] travelled;
        logic              wall_found;
        logic              step_bound_hit;
    } march_result_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [IDX_W-1:0]          col;
        logic [IDX_W-1:0]          row;
        logic signed [CELL_W-1:0]  cell_val;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [HEAD_W-1:0]  hx;
        logic signed [HEAD_W-1:0]  hy;
        logic [DIST_W-1:0]         lim;
        logic                      has_want;
        march_result_t             want;
    } ray_item_t;

    // clock, reset and block ports
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid      = 1'b0;
    logic                      in_stall;
    logic [OP_W-1:0]           op            = OP_WRITE;
    logic [IDX_W-1:0]          cell_column   = '0;
    logic [IDX_W-1:0]          cell_row      = '0;
    logic signed [CELL_W-1:0]  cell_distance = '0;
    logic signed [COORD_W-1:0] start_x       = '0;
    logic signed [COORD_W-1:0] start_y       = '0;
    logic signed [HEAD_W-1:0]  heading_x     = '0;
    logic signed [HEAD_W-1:0]  heading_y     = '0;
    logic [DIST_W-1:0]         range_limit   = '0;

    logic                      out_valid;
    logic                      out_stall     = 1'b0;
    logic [DIST_W-1:0]         travelled;
    logic                      wall_found;
    logic                      step_bound_hit;

    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index     = '0;
    logic [CFG_DATA_W-1:0]     cfg_data      = '0;

    // predictor state: map copy, register copies, pending march results
    logic signed [CELL_W-1:0] dist_map [0:COLS_MAX*ROWS_MAX-1];
    logic [DIM_W-1:0]         cols_reg  = MAP_COLUMNS_RST;
    logic [DIM_W-1:0]         rows_reg  = MAP_ROWS_RST;
    logic [PSIZE_W-1:0]       size_reg  = PIXEL_SIZE_RST;
    logic [PSCALE_W-1:0]      scale_reg = PIXEL_SCALE_RST;
    march_result_t            march_q [$];

    int mismatches = 0;
    bit idle_on    = 1'b1;

    distance_field_ray_march u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .cell_column    (cell_column),
        .cell_row       (cell_row),
        .cell_distance  (cell_distance),
        .start_x        (start_x),
        .start_y        (start_y),
        .heading_x      (heading_x),
        .heading_y      (heading_y),
        .range_limit    (range_limit),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .travelled      (travelled),
        .wall_found     (wall_found),
        .step_bound_hit (step_bound_hit),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // divide by 2^s, halves away from zero
    function automatic longint round_away(input longint v, input int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic int dim_eff(input logic [DIM_W-1:0] r, input int top);
        if (r == 0)
            return 1;
        if (int'(r) > top)
            return top;
        return int'(r);
    endfunction

    function automatic int clamp_pixel(input longint v, input int n);
        if (v < 0)
            return 0;
        if (v >= n)
            return n - 1;
        return int'(v);
    endfunction

    // sphere trace one ray over the map copy
    function automatic march_result_t trace_ray(input ray_item_t it);
        longint sx, sy, hx, hy, lim, eps, t, px, py, d;
        int cols, rows, cx, cy;
        march_result_t res;
        sx   = longint'($signed(it.sx));
        sy   = longint'($signed(it.sy));
        hx   = longint'($signed(it.hx));
        hy   = longint'($signed(it.hy));
        lim  = longint'(it.lim);
        eps  = (3 * longint'(size_reg) + 1) >>> 1;
        cols = dim_eff(cols_reg, COLS_MAX);
        rows = dim_eff(rows_reg, ROWS_MAX);
        t    = 0;
        res.travelled      = it.lim;
        res.wall_found     = 1'b0;
        res.step_bound_hit = 1'b1;
        for (int n = 0; n < STEP_BOUND; n++)
        begin
            px = sx + round_away(hx * t, OFS_SHIFT);
            py = sy + round_away(hy * t, OFS_SHIFT);
            cx = clamp_pixel(round_away(px * longint'(scale_reg), PIX_SHIFT), cols);
            cy = clamp_pixel(round_away(py * longint'(scale_reg), PIX_SHIFT), rows);
            d  = dist_map[cy * COLS_MAX + cx];
            if (d < 0)
            begin
                res.travelled      = t[DIST_W-1:0];
                res.wall_found     = 1'b1;
                res.step_bound_hit = 1'b0;
                break;
            end
            t = t + d + eps;
            if (t >= lim)
            begin
                res.step_bound_hit = 1'b0;
                break;
            end
        end
        return res;
    endfunction

    function automatic ray_item_t wr(input int col, input int row, input int cell_val);
        ray_item_t it;
        it          = '0;
        it.op       = OP_WRITE;
        it.col      = IDX_W'(col);
        it.row      = IDX_W'(row);
        it.cell_val = CELL_W'(cell_val);
        return it;
    endfunction

    function automatic ray_item_t qry(input int sx, input int sy, input int hx, input int hy,
                                      input int lim, input bit has_want, input int t_want,
                                      input bit w_want, input bit b_want);
        ray_item_t it;
        it                     = '0;
        it.op                  = OP_QUERY;
        it.sx                  = COORD_W'(sx);
        it.sy                  = COORD_W'(sy);
        it.hx                  = HEAD_W'(hx);
        it.hy                  = HEAD_W'(hy);
        it.lim                 = DIST_W'(lim);
        it.has_want            = has_want;
        it.want.travelled      = DIST_W'(t_want);
        it.want.wall_found     = w_want;
        it.want.step_bound_hit = b_want;
        return it;
    endfunction

    // fill value: mostly water, now and then a wall
    function automatic int fill_value();
        if ($urandom_range(0, 11) == 0)
            return -int'($urandom_range(1, 32768));
        return int'($urandom_range(128, 2048));
    endfunction

    // start coordinate: mostly over the map in use, some half-metre ties, some anywhere
    function automatic logic [COORD_W-1:0] pick_coord(input int n);
        int span, sel;
        span = n * int'(size_reg);
        if (span > 8388607)
            span = 8388607;
        if (span == 0)
            span = 4096;
        sel = $urandom_range(0, 19);
        if (sel < 14)
            return COORD_W'($urandom_range(0, span));
        if (sel < 16)
            return COORD_W'(128 * (int'($urandom_range(0, 24)) - 4));
        if (sel < 18)
            return COORD_W'(-int'($urandom_range(0, 2048)));
        return COORD_W'($urandom());
    endfunction

    function automatic ray_item_t random_item();
        ray_item_t it;
        int cols, rows, sel, hx, hy;
        real ang;
        it   = '0;
        cols = dim_eff(cols_reg, COLS_MAX);
        rows = dim_eff(rows_reg, ROWS_MAX);
        if ($urandom_range(0, 9) < 4)
        begin
            it.op = OP_WRITE;
            if ($urandom_range(0, 4) != 0)
            begin
                it.col = IDX_W'($urandom_range(0, cols - 1));
                it.row = IDX_W'($urandom_range(0, rows - 1));
            end
            else
            begin
                it.col = IDX_W'($urandom_range(0, 255));
                it.row = IDX_W'($urandom_range(0, 255));
            end
            sel = $urandom_range(0, 19);
            if (sel < 16)
                it.cell_val = CELL_W'($urandom_range(128, 2048));
            else if (sel < 19)
                it.cell_val = CELL_W'(-int'($urandom_range(1, 2048)));
            else
                it.cell_val = CELL_W'($urandom());
        end
        else
        begin
            it.op = OP_QUERY;
            it.sx = pick_coord(cols);
            it.sy = pick_coord(rows);
            // unit headings mostly, then arbitrary ones, then axis, diagonal and zero ones
            sel = $urandom_range(0, 9);
            if (sel < 6)
            begin
                ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
                hx  = $rtoi($cos(ang) * 16384.0);
                hy  = $rtoi($sin(ang) * 16384.0);
            end
            else if (sel < 9)
            begin
                hx = int'($urandom_range(0, 32768)) - 16384;
                hy = int'($urandom_range(0, 32768)) - 16384;
            end
            else
            begin
                hx = 16384 * (int'($urandom_range(0, 2)) - 1);
                hy = 16384 * (int'($urandom_range(0, 2)) - 1);
            end
            it.hx = HEAD_W'(hx);
            it.hy = HEAD_W'(hy);
            // short limits keep marches brief; a few span the whole field
            sel = $urandom_range(0, 99);
            if (sel < 3)
                it.lim = DIST_W'($urandom_range(0, 8388607));
            else if (sel < 8)
                it.lim = DIST_W'($urandom_range(0, 65535));
            else
                it.lim = DIST_W'($urandom_range(0, 16383));
        end
        return it;
    endfunction

    // present one item, hold it until taken, then update the predictor
    task automatic send_item(input ray_item_t it);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= it.op;
        cell_column   <= it.col;
        cell_row      <= it.row;
        cell_distance <= it.cell_val;
        start_x       <= it.sx;
        start_y       <= it.sy;
        heading_x     <= it.hx;
        heading_y     <= it.hy;
        range_limit   <= it.lim;
        do
            @(posedge clk);
        while (in_stall);
        if (it.op == OP_WRITE)
            dist_map[int'(it.row) * COLS_MAX + int'(it.col)] = it.cell_val;
        else if (it.has_want)
            march_q.push_back(it.want);
        else
            march_q.push_back(trace_ray(it));
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MAP_COLUMNS: cols_reg  = DIM_W'(value);
            REG_MAP_ROWS:    rows_reg  = DIM_W'(value);
            REG_PIXEL_SIZE:  size_reg  = PSIZE_W'(value);
            REG_PIXEL_SCALE: scale_reg = PSCALE_W'(value);
            default: ;
        endcase
    endtask

    task automatic set_config(input int cols, input int rows, input int psize, input int pscale);
        cfg_write(REG_MAP_COLUMNS, cols);
        cfg_write(REG_MAP_ROWS, rows);
        cfg_write(REG_PIXEL_SIZE, psize);
        cfg_write(REG_PIXEL_SCALE, pscale);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, wait for every outstanding result, then let a last write retire
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (march_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // result side stalls in random bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // compare each result with the oldest pending march
    always @(posedge clk)
    begin : check_results
        march_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (march_q.size() == 0)
            begin
                $display("%0t: result travelled %0d with no query outstanding", $time, travelled);
                mismatches++;
            end
            else
            begin
                want = march_q.pop_front();
                if (travelled !== want.travelled)
                begin
                    $display("%0t: travelled expected %0d actual %0d",
                             $time, want.travelled, travelled);
                    mismatches++;
                end
                if (wall_found !== want.wall_found)
                begin
                    $display("%0t: wall_found expected %0b actual %0b",
                             $time, want.wall_found, wall_found);
                    mismatches++;
                end
                if (step_bound_hit !== want.step_bound_hit)
                begin
                    $display("%0t: step_bound_hit expected %0b actual %0b",
                             $time, want.step_bound_hit, step_bound_hit);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        ray_item_t dir_tab [$];
        int cols, rows, psize, pscale;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the corner block and column 0 so that no query reads an unwritten cell
        for (int r = 0; r < ROWS_MAX; r++)
            for (int c = 0; c < ((r < FILL_DIM) ? FILL_DIM : 1); c++)
                send_item(wr(c, r, fill_value()));

        // the map in use is kept inside the filled cells from here on
        wait_idle();
        set_config(FILL_DIM, FILL_DIM, PIXEL_SIZE_RST, PIXEL_SCALE_RST);

        // directed rows under the reset pixel size and scale; expectation typed where obvious
        //                  sx        sy        hx      hy      limit    typed  trav  wall bound
        dir_tab.push_back(wr(0, 0, -1));
        dir_tab.push_back(qry(0,        0,        16384,  0,      1000,    1, 0,       1, 0));
        dir_tab.push_back(wr(0, 0, -32768));
        // zero limit on a wall
        dir_tab.push_back(qry(0,        0,        0,      -16384, 0,       1, 0,       1, 0));
        dir_tab.push_back(wr(0, 0, 32767));
        // zero limit in water
        dir_tab.push_back(qry(0,        0,        -16384, 0,      0,       1, 0,       0, 0));
        // far negative corner clamps to the first cell
        dir_tab.push_back(qry(-8388608, -8388608, 16384,  16384,  100,     1, 100,     0, 0));
        dir_tab.push_back(qry(0,        0,        16384,  0,      8388607, 0, 0,       0, 0));
        dir_tab.push_back(wr(FILL_DIM - 1, FILL_DIM - 1, -256));
        // far positive corner clamps to the last cell
        dir_tab.push_back(qry(8388607,  8388607,  -16384, -16384, 8388607, 1, 0,       1, 0));
        // zero heading on a zero cell runs into the step bound
        dir_tab.push_back(wr(0, 0, 0));
        dir_tab.push_back(qry(0,        0,        0,      0,      8388607, 1, 8388607, 0, 1));
        dir_tab.push_back(qry(0,        0,        0,      0,      39,      1, 39,      0, 0));
        dir_tab.push_back(qry(0,        0,        0,      0,      40,      1, 40,      0, 0));
        dir_tab.push_back(wr(0, 0, 512));
        // half-way heading offsets round away from zero
        dir_tab.push_back(qry(512,      512,      8192,   8192,   3000,    0, 0,       0, 0));
        dir_tab.push_back(qry(512,      512,      -8192,  8192,   3000,    0, 0,       0, 0));
        dir_tab.push_back(qry(2560,     -2560,    11585,  -11585, 20000,   0, 0,       0, 0));
        dir_tab.push_back(qry(-512,     2560,     16384,  0,      20000,   0, 0,       0, 0));
        dir_tab.push_back(wr(17, 200, 32767));
        dir_tab.push_back(qry(4000,     50000,    0,      -16384, 8000,    0, 0,       0, 0));
        foreach (dir_tab[i])
            send_item(dir_tab[i]);

        // random phases; each phase after the first sets its configuration anew
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait_idle();
                case (ph)
                    1: begin cols = 1;   rows = 1;   psize = 65535; pscale = 16777215; end
                    2: begin cols = 0;   rows = 511; psize = 1;     pscale = 1;        end
                    3:
                    begin
                        cols   = FILL_DIM;
                        rows   = FILL_DIM;
                        psize  = 0;
                        pscale = 65536;
                    end
                    4:
                    begin
                        cols   = FILL_DIM - 3;
                        rows   = FILL_DIM;
                        psize  = $urandom_range(8, 512);
                        pscale = $urandom_range(16384, 1 << 20);
                    end
                    default:
                    begin
                        cols   = FILL_DIM;
                        rows   = FILL_DIM;
                        psize  = PIXEL_SIZE_RST;
                        pscale = PIXEL_SCALE_RST;
                    end
                endcase
                set_config(cols, rows, psize, pscale);
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // the last phase runs flat out on both sides
                if (i % 40 == 0)
                    idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
                send_item(random_item());
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
